// File: rtl/core/msgm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-stream gain mixer package
// Shared widths, constants and the pipeline control type for the mixer.
// ----------------------------------------------------------------------------
package msgm_pkg;

    // Number of streams mixed and number of gain registers.
    localparam int STREAMS    = 8;
    localparam int GAIN_COUNT = 8;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 7;
    localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
    // |sample * gain| is at most 32768 * 100, which fits in 22 bits.
    localparam int MAG_W    = 22;

    // Division by 100 as a multiplication by a rounded-up reciprocal.
    // The result is exact for every magnitude below 2^29 / 88.
    localparam int RECIP_SHIFT = 29;
    localparam int RECIP_W     = 23;
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(5368710);
    localparam int MUL_W       = MAG_W + RECIP_W;
    localparam int QUOT_W      = 16;

    localparam int TERM_W = QUOT_W + 1;
    localparam int SUM_W  = TERM_W + $clog2(STREAMS);

    localparam logic [GAIN_W-1:0] GAIN_FULL = GAIN_W'(100);

    // Configuration port.
    localparam int ADDR_W = $clog2(GAIN_COUNT) + 2;
    localparam int DATA_W = 32;

    // Stage enables handed to each scaling lane.
    typedef struct packed {
        logic en1;
        logic en2;
    } t_stage_ctrl;

endpackage

// File: rtl/core/msgm_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gain scaling lane
// Two pipeline stages: sample times gain, then division by 100 toward zero.
// ----------------------------------------------------------------------------
module msgm_scale (
    input  logic                                i_clk,
    input  msgm_pkg::t_stage_ctrl               i_ctrl,
    input  logic signed [msgm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic        [msgm_pkg::GAIN_W-1:0]   i_gain,
    input  logic                                i_use,
    output logic signed [msgm_pkg::TERM_W-1:0]   o_term
);

    logic        [msgm_pkg::GAIN_W-1:0] w_gain;
    logic signed [msgm_pkg::PROD_W-1:0] n_prod;
    logic signed [msgm_pkg::PROD_W-1:0] r_prod;
    logic        [msgm_pkg::PROD_W-1:0] w_abs;
    logic        [msgm_pkg::MUL_W-1:0]  n_mul;
    logic        [msgm_pkg::QUOT_W-1:0] r_quot;
    logic                               r_neg;
    logic signed [msgm_pkg::TERM_W-1:0] w_quot;

    // Gains above full scale count as full scale.
    assign w_gain = (i_gain > msgm_pkg::GAIN_FULL) ? msgm_pkg::GAIN_FULL : i_gain;

    always_comb begin
        if (i_use) begin
            n_prod = msgm_pkg::PROD_W'(i_sample * $signed({1'b0, w_gain}));
        end else begin
            n_prod = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en1) begin
            r_prod <= n_prod;
        end
    end

    assign w_abs = r_prod[msgm_pkg::PROD_W-1] ? msgm_pkg::PROD_W'(-r_prod)
                                              : msgm_pkg::PROD_W'(r_prod);
    assign n_mul = msgm_pkg::MUL_W'(w_abs[msgm_pkg::MAG_W-1:0])
                 * msgm_pkg::MUL_W'(msgm_pkg::RECIP_M);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en2) begin
            r_quot <= n_mul[msgm_pkg::RECIP_SHIFT +: msgm_pkg::QUOT_W];
            r_neg  <= r_prod[msgm_pkg::PROD_W-1];
        end
    end

    assign w_quot = $signed({1'b0, r_quot});
    assign o_term = r_neg ? -w_quot : w_quot;

endmodule

// File: rtl/core/multi_stream_gain_mixer.sv
`timescale 1ns / 1ps
// A request accepted at a rising edge passes through the product, divide, sum and
// saturate registers in turn, the last of which drives o_valid and the result.
// Throughput: one request per cycle while the output is not stalled; each stage
// holds its item only while the stage after it is full and stalled.
// Reset: synchronous, active low; clears the pipeline and sets every gain to 100.
// ----------------------------------------------------------------------------
// Multi-stream gain mixer
// Scales up to eight signed samples by per-stream gain percentages, sums the
// contributing terms and saturates the sum to 16 bits with a clip flag.
// ----------------------------------------------------------------------------
module multi_stream_gain_mixer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    // Input channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [msgm_pkg::SAMPLE_W-1:0] i_sample_s0,
    input  logic signed [msgm_pkg::SAMPLE_W-1:0] i_sample_s1,
    input  logic signed [msgm_pkg::SAMPLE_W-1:0] i_sample_s2,
    input  logic signed [msgm_pkg::SAMPLE_W-1:0] i_sample_s3,
    input  logic signed [msgm_pkg::SAMPLE_W-1:0] i_sample_s4,
    input  logic signed [msgm_pkg::SAMPLE_W-1:0] i_sample_s5,
    input  logic signed [msgm_pkg::SAMPLE_W-1:0] i_sample_s6,
    input  logic signed [msgm_pkg::SAMPLE_W-1:0] i_sample_s7,
    input  logic        [7:0]                    i_contribute_mask,

    // Output channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [msgm_pkg::SAMPLE_W-1:0] o_mixed_sample,
    output logic                                 o_clipped,

    // Configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic        [msgm_pkg::ADDR_W-1:0]   paddr,
    input  logic        [msgm_pkg::DATA_W-1:0]   pwdata,
    output logic        [msgm_pkg::DATA_W-1:0]   prdata,
    output logic                                 pready
);

    localparam int IDX_W = $clog2(msgm_pkg::GAIN_COUNT);

    // Largest and smallest 16-bit values, at the width of the sum.
    localparam logic signed [msgm_pkg::SUM_W-1:0] SUM_MAX =
        msgm_pkg::SUM_W'(32767);
    localparam logic signed [msgm_pkg::SUM_W-1:0] SUM_MIN =
        -msgm_pkg::SUM_W'(32768);

    // ------------------------------------------------------------------
    // Gain registers. Configuration must only be written while the pipeline
    // is empty (not enforced here), so the lanes read the registers directly.
    // ------------------------------------------------------------------
    logic [msgm_pkg::GAIN_W-1:0] r_gain [msgm_pkg::GAIN_COUNT];
    logic [IDX_W-1:0]            w_idx;
    logic                        w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[IDX_W+1:2];
    assign w_wr   = psel && penable && pwrite && pready;
    assign prdata = msgm_pkg::DATA_W'(r_gain[w_idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < msgm_pkg::GAIN_COUNT; i++) begin
                r_gain[i] <= msgm_pkg::GAIN_FULL;
            end
        end else if (w_wr) begin
            r_gain[w_idx] <= pwdata[msgm_pkg::GAIN_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. Stage 1 holds the products, stage 2 the quotients,
    // stage 3 the sum and stage 4 the output register. A stage takes a new
    // item when it is empty or when the stage after it moves on, so bubbles
    // are squeezed out and nothing is lost or repeated under a stall.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4;
    logic w_en1, w_en2, w_en3, w_en4;
    msgm_pkg::t_stage_ctrl w_ctrl;

    assign w_en4   = !r_v4 || !i_stall;
    assign w_en3   = !r_v3 || w_en4;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_stall = !w_en1;
    assign o_valid = r_v4;

    assign w_ctrl.en1 = w_en1;
    assign w_ctrl.en2 = w_en2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 1 and 2: one scaling lane per stream. A stream whose mask bit
    // is clear enters as a zero product and adds nothing to the sum.
    // ------------------------------------------------------------------
    logic signed [msgm_pkg::SAMPLE_W-1:0] w_sample [8];
    logic signed [msgm_pkg::TERM_W-1:0]   w_term   [msgm_pkg::STREAMS];

    assign w_sample[0] = i_sample_s0;
    assign w_sample[1] = i_sample_s1;
    assign w_sample[2] = i_sample_s2;
    assign w_sample[3] = i_sample_s3;
    assign w_sample[4] = i_sample_s4;
    assign w_sample[5] = i_sample_s5;
    assign w_sample[6] = i_sample_s6;
    assign w_sample[7] = i_sample_s7;

    for (genvar g = 0; g < msgm_pkg::STREAMS; g++) begin : g_lane
        msgm_scale u_scale (
            .i_clk    (i_clk),
            .i_ctrl   (w_ctrl),
            .i_sample (w_sample[g]),
            .i_gain   (r_gain[g]),
            .i_use    (i_contribute_mask[g]),
            .o_term   (w_term[g])
        );
    end

    // ------------------------------------------------------------------
    // Stage 3: the exact sum of the signed terms. It cannot overflow, as
    // the sum width has room for every stream at full scale.
    // ------------------------------------------------------------------
    logic signed [msgm_pkg::SUM_W-1:0] n_sum;
    logic signed [msgm_pkg::SUM_W-1:0] r_sum;

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < msgm_pkg::STREAMS; i++) begin
            n_sum = n_sum + msgm_pkg::SUM_W'(w_term[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_sum <= n_sum;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: saturate to 16 bits into the output register, flagging a
    // clip whenever the sum lay outside the 16-bit range.
    // ------------------------------------------------------------------
    logic signed [msgm_pkg::SAMPLE_W-1:0] n_mixed;
    logic                                 n_clip;
    logic signed [msgm_pkg::SAMPLE_W-1:0] r_mixed;
    logic                                 r_clip;

    always_comb begin
        if (r_sum > SUM_MAX) begin
            n_mixed = SUM_MAX[msgm_pkg::SAMPLE_W-1:0];
            n_clip  = 1'b1;
        end else if (r_sum < SUM_MIN) begin
            n_mixed = SUM_MIN[msgm_pkg::SAMPLE_W-1:0];
            n_clip  = 1'b1;
        end else begin
            n_mixed = r_sum[msgm_pkg::SAMPLE_W-1:0];
            n_clip  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_mixed <= n_mixed;
            r_clip  <= n_clip;
        end
    end

    assign o_mixed_sample = r_mixed;
    assign o_clipped      = r_clip;

endmodule
